FILE: sv/lgfs_pkg.sv
// Shared constants and types for the LED grayscale frame serializer.
package lgfs_pkg;

  localparam int DRIVER_CHIPS      = 2;
  localparam int CHANNELS_PER_CHIP = 24;
  localparam int GRAY_BITS         = 12;
  localparam int LOAD_SHIFT        = 4;
  localparam int BIT_W             = $clog2(GRAY_BITS);
  localparam int MODE_W            = 2;
  localparam int RX_W              = 8;
  localparam int OFFSET_W          = 6;

  typedef logic [GRAY_BITS-1:0] gray_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

endpackage

FILE: sv/lgfs_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface lgfs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lgfs_pkg::MODE_W-1:0]          mode;
  logic [lgfs_pkg::RX_W-1:0]            rx_byte;
  logic [lgfs_pkg::OFFSET_W-1:0]        start_offset;

  modport source (output valid, mode, rx_byte, start_offset, input ready);
  modport sink   (input valid, mode, rx_byte, start_offset, output ready);
endinterface

interface lgfs_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic clock_pulse;
  logic latch_pulse;
  logic frame_ready;
  logic busy_res;

  modport source (output valid, data_bit, clock_pulse, latch_pulse, frame_ready, busy_res,
                  input ready);
  modport sink   (input valid, data_bit, clock_pulse, latch_pulse, frame_ready, busy_res,
                  output ready);
endinterface

FILE: sv/lgfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgfs_ram #(
  parameter int WIDTH = lgfs_pkg::GRAY_BITS,
  parameter int DEPTH = lgfs_pkg::DRIVER_CHIPS * lgfs_pkg::CHANNELS_PER_CHIP
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/led_grayscale_frame_serializer.sv
// Top level: channel store, frame sequencing and serial bit output.
//
// One beat is accepted every cycle while the output side keeps up; an output
// stall holds the input. The accept edge updates the counters and issues the
// channel store read, and as s1 advances the bit is picked out of the
// registered read data into the output register. The store is a RAM of
// DRIVER_CHIPS*24 twelve-bit entries with one write and one read port; a
// per-entry valid flag cleared at reset makes unwritten entries read as zero,
// so the block takes beats right out of reset. A load writes the byte times 16
// at the running write index and flags frame_ready when the index wraps; a
// start beat (ignored while a frame is out) latches the rotation offset; each
// tick beat sends one bit MSB first with a clock pulse, and the last bit of
// the frame carries the latch pulse.
module led_grayscale_frame_serializer #(
  parameter int DRIVER_CHIPS = lgfs_pkg::DRIVER_CHIPS
) (
  input  logic        clk,
  input  logic        rst_n,
  lgfs_in_if.sink     in_ch,
  lgfs_out_if.source  out_ch
);

  localparam int TOTAL_CH = DRIVER_CHIPS * lgfs_pkg::CHANNELS_PER_CHIP;
  localparam int CH_W     = $clog2(TOTAL_CH);
  localparam int CALC_W   = CH_W + 2;
  localparam int BIT_W    = lgfs_pkg::BIT_W;

  localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(TOTAL_CH - 1);
  localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(lgfs_pkg::GRAY_BITS - 1);
  localparam logic [CALC_W-1:0] TOT_CALC = CALC_W'(TOTAL_CH);
  localparam logic [CH_W:0]     TOT_SUM  = (CH_W+1)'(TOTAL_CH);

  typedef struct packed {
    logic             tick;
    logic             entry_ok;
    logic [BIT_W-1:0] bit_sel;
    logic             clock_pulse;
    logic             latch_pulse;
    logic             frame_ready;
    logic             busy;
  } s1_t;

  // frame state
  logic [CH_W-1:0]     wr_idx_r, wr_idx_nxt;
  logic                sending_r, sending_nxt;
  logic [CH_W-1:0]     chan_cnt_r, chan_cnt_nxt;
  logic [BIT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [CH_W-1:0]     offset_r, offset_nxt;
  logic [TOTAL_CH-1:0] filled_r, filled_nxt;

  // pipeline
  s1_t  s1_r, s1_nxt;
  logic s1_valid_r;
  logic out_valid_r;
  logic out_data_r, out_clk_r, out_latch_r, out_ready_r, out_busy_r;

  logic in_fire;
  logic s1_adv;

  // store ports
  logic                      ram_we;
  logic                      ram_re;
  logic [CH_W-1:0]           rd_addr;
  logic [lgfs_pkg::GRAY_BITS-1:0] rd_data;
  lgfs_pkg::gray_t           wr_data;

  // offset reduction and rotated channel
  logic [CALC_W-1:0] offs0, offs1, offs2;
  logic [CH_W:0]     ch_sum, ch_rot;
  logic [BIT_W-1:0]  bit_idx;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // offset is below 64 and the channel count at least 24: two subtracts suffice
  assign offs0 = CALC_W'(in_ch.start_offset);
  assign offs1 = (offs0 >= TOT_CALC) ? offs0 - TOT_CALC : offs0;
  assign offs2 = (offs1 >= TOT_CALC) ? offs1 - TOT_CALC : offs1;

  assign ch_sum  = {1'b0, chan_cnt_r} + {1'b0, offset_r};
  assign ch_rot  = (ch_sum >= TOT_SUM) ? ch_sum - TOT_SUM : ch_sum;
  assign rd_addr = ch_rot[CH_W-1:0];

  assign wr_data = lgfs_pkg::gray_t'(in_ch.rx_byte) << lgfs_pkg::LOAD_SHIFT;

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    sending_nxt  = sending_r;
    chan_cnt_nxt = chan_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    offset_nxt   = offset_r;
    filled_nxt   = filled_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    s1_nxt       = '0;
    unique case (lgfs_pkg::mode_t'(in_ch.mode))
      lgfs_pkg::MODE_LOAD: begin
        ram_we = in_fire;
        filled_nxt[wr_idx_r] = 1'b1;
        if (wr_idx_r == LAST_CH) begin
          wr_idx_nxt         = '0;
          s1_nxt.frame_ready = 1'b1;
        end else begin
          wr_idx_nxt = wr_idx_r + 1'b1;
        end
      end
      lgfs_pkg::MODE_START: begin
        if (!sending_r) begin
          sending_nxt  = 1'b1;
          chan_cnt_nxt = '0;
          bit_cnt_nxt  = '0;
          offset_nxt   = offs2[CH_W-1:0];
        end
      end
      lgfs_pkg::MODE_TICK: begin
        if (sending_r) begin
          ram_re             = in_fire;
          s1_nxt.tick        = 1'b1;
          s1_nxt.entry_ok    = filled_r[rd_addr];
          s1_nxt.bit_sel     = bit_cnt_r;
          s1_nxt.clock_pulse = 1'b1;
          if (bit_cnt_r == LAST_BIT) begin
            bit_cnt_nxt = '0;
            if (chan_cnt_r == LAST_CH) begin
              chan_cnt_nxt       = '0;
              sending_nxt        = 1'b0;
              s1_nxt.latch_pulse = 1'b1;
            end else begin
              chan_cnt_nxt = chan_cnt_r + 1'b1;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    s1_nxt.busy = sending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      sending_r  <= 1'b0;
      chan_cnt_r <= '0;
      bit_cnt_r  <= '0;
      offset_r   <= '0;
      filled_r   <= '0;
    end else if (in_fire) begin
      wr_idx_r   <= wr_idx_nxt;
      sending_r  <= sending_nxt;
      chan_cnt_r <= chan_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      offset_r   <= offset_nxt;
      filled_r   <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign bit_idx = LAST_BIT - s1_r.bit_sel;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      // read data stays put until the next tick read, which only issues as s1 moves on
      out_data_r  <= s1_r.tick && s1_r.entry_ok && rd_data[bit_idx];
      out_clk_r   <= s1_r.clock_pulse;
      out_latch_r <= s1_r.latch_pulse;
      out_ready_r <= s1_r.frame_ready;
      out_busy_r  <= s1_r.busy;
    end
  end

  lgfs_ram #(
    .WIDTH (lgfs_pkg::GRAY_BITS),
    .DEPTH (TOTAL_CH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx_r),
    .wr_data (wr_data),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_bit    = out_data_r;
  assign out_ch.clock_pulse = out_clk_r;
  assign out_ch.latch_pulse = out_latch_r;
  assign out_ch.frame_ready = out_ready_r;
  assign out_ch.busy_res    = out_busy_r;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the LED grayscale frame serializer: load, start and shift beats.
`timescale 1ns / 1ps

module testbench;

  localparam int TOTAL_CH     = lgfs_pkg::DRIVER_CHIPS * lgfs_pkg::CHANNELS_PER_CHIP;
  localparam int FRAME_BITS   = TOTAL_CH * lgfs_pkg::GRAY_BITS;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 60;
  localparam logic [lgfs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [lgfs_pkg::MODE_W-1:0]   mode;
    logic [lgfs_pkg::RX_W-1:0]     rx_byte;
    logic [lgfs_pkg::OFFSET_W-1:0] start_offset;
  } host_cmd_t;

  typedef struct packed {
    logic data_bit;
    logic clock_pulse;
    logic latch_pulse;
    logic frame_ready;
    logic busy_res;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n;

  lgfs_in_if  in_ch ();
  lgfs_out_if out_ch ();

  led_grayscale_frame_serializer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the serializer
  lgfs_pkg::gray_t     gray_store [TOTAL_CH];
  logic [5:0]          load_ptr;
  logic                shifting;
  logic [5:0]          chan_pos;
  logic [3:0]          bit_pos;
  logic [5:0]          rot;

  host_cmd_t           host_cmds [$];
  pin_state_t          pin_states_due [$];
  host_cmd_t           next_cmd;
  pin_state_t          seen;
  pin_state_t          due;
  logic                in_took;

  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  beats_queued;
  int                  beats_in;
  int                  results_checked;
  int                  mismatches;
  int                  latches_seen;
  int                  wraps_seen;
  int                  quiet_cycles;
  int                  mode_hits [4];

  // Stimulus-side estimate of frame progress, used only to shape the mix
  logic                gen_busy;
  int                  gen_ticks_left;
  int                  gen_frames;

  string field_names [5] = '{"data_bit", "clock_pulse", "latch_pulse", "frame_ready",
                             "busy_res"};

  function automatic pin_state_t drive_pins(logic [lgfs_pkg::MODE_W-1:0]   mode,
                                            logic [lgfs_pkg::RX_W-1:0]     rx,
                                            logic [lgfs_pkg::OFFSET_W-1:0] offs);
    pin_state_t p;
    int         ch;
    p = '0;
    case (mode)
      lgfs_pkg::MODE_LOAD: begin
        gray_store[load_ptr] = {rx, 4'b0000};
        if (load_ptr == TOTAL_CH - 1) begin
          load_ptr      = '0;
          p.frame_ready = 1'b1;
        end else begin
          load_ptr = load_ptr + 1'b1;
        end
      end
      lgfs_pkg::MODE_START: begin
        if (!shifting) begin
          shifting = 1'b1;
          chan_pos = '0;
          bit_pos  = '0;
          rot      = 6'(int'(offs) % TOTAL_CH);
        end
      end
      lgfs_pkg::MODE_TICK: begin
        if (shifting) begin
          ch = int'(chan_pos) + int'(rot);
          if (ch >= TOTAL_CH) ch -= TOTAL_CH;
          p.data_bit    = gray_store[ch][lgfs_pkg::GRAY_BITS - 1 - int'(bit_pos)];
          p.clock_pulse = 1'b1;
          if (bit_pos == lgfs_pkg::GRAY_BITS - 1) begin
            bit_pos = '0;
            if (chan_pos == TOTAL_CH - 1) begin
              chan_pos      = '0;
              shifting      = 1'b0;
              p.latch_pulse = 1'b1;
            end else begin
              chan_pos = chan_pos + 1'b1;
            end
          end else begin
            bit_pos = bit_pos + 1'b1;
          end
        end
      end
      default: ;
    endcase
    p.busy_res = shifting;
    return p;
  endfunction

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic push_cmd(logic [lgfs_pkg::MODE_W-1:0]   mode,
                          logic [lgfs_pkg::RX_W-1:0]     rx,
                          logic [lgfs_pkg::OFFSET_W-1:0] offs);
    host_cmd_t c;
    c.mode         = mode;
    c.rx_byte      = rx;
    c.start_offset = offs;
    if (mode == lgfs_pkg::MODE_START && !gen_busy) begin
      gen_busy       = 1'b1;
      gen_ticks_left = FRAME_BITS;
    end else if (mode == lgfs_pkg::MODE_TICK && gen_busy) begin
      gen_ticks_left--;
      if (gen_ticks_left == 0) begin
        gen_busy = 1'b0;
        gen_frames++;
      end
    end
    host_cmds.push_back(c);
    beats_queued++;
  endtask

  // Mostly whole frames of ticks once started; loads and noise sprinkled in.
  task automatic queue_random(int n);
    int                          r;
    logic [lgfs_pkg::MODE_W-1:0] m;
    repeat (n) begin
      r = $urandom_range(99);
      if (gen_busy) begin
        if (r < 92)      m = lgfs_pkg::MODE_TICK;
        else if (r < 96) m = lgfs_pkg::MODE_LOAD;
        else if (r < 98) m = lgfs_pkg::MODE_START;
        else             m = MODE_UNUSED;
      end else begin
        if (r < 60)      m = lgfs_pkg::MODE_LOAD;
        else if (r < 70) m = lgfs_pkg::MODE_START;
        else if (r < 92) m = lgfs_pkg::MODE_TICK;
        else             m = MODE_UNUSED;
      end
      push_cmd(m, 8'($urandom_range(255)), 6'($urandom_range(63)));
    end
  endtask

  task automatic wait_idle();
    while (beats_in != beats_queued || pin_states_due.size() != 0) @(negedge clk);
  endtask

  // Driver: new beat only once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (host_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = host_cmds.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= next_cmd.mode;
        in_ch.rx_byte      <= next_cmd.rx_byte;
        in_ch.start_offset <= next_cmd.start_offset;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor, predictor hookup and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.data_bit, out_ch.clock_pulse, out_ch.latch_pulse, out_ch.frame_ready,
                out_ch.busy_res};
        if (pin_states_due.size() == 0) begin
          report_error($sformatf("result %0d arrived with no beat outstanding",
                                 results_checked));
        end else begin
          due = pin_states_due.pop_front();
          for (int k = 0; k < 5; k++) begin
            if (seen[4 - k] !== due[4 - k])
              report_error($sformatf("result %0d %s: got %b want %b", results_checked,
                                     field_names[k], seen[4 - k], due[4 - k]));
          end
          if (due.latch_pulse) latches_seen++;
          if (due.frame_ready) wraps_seen++;
        end
        results_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pin_states_due.push_back(drive_pins(in_ch.mode, in_ch.rx_byte, in_ch.start_offset));
        mode_hits[in_ch.mode]++;
        beats_in++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                   QUIET_LIMIT, pin_states_due.size());
          $display("led_grayscale_frame_serializer regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = lgfs_pkg::MODE_LOAD;
    in_ch.rx_byte      = '0;
    in_ch.start_offset = '0;
    out_ch.ready       = 1'b0;
    foreach (gray_store[k]) gray_store[k] = '0;
    load_ptr        = '0;
    shifting        = 1'b0;
    chan_pos        = '0;
    bit_pos         = '0;
    rot             = '0;
    beats_queued    = 0;
    beats_in        = 0;
    results_checked = 0;
    mismatches      = 0;
    latches_seen    = 0;
    wraps_seen      = 0;
    quiet_cycles    = 0;
    foreach (mode_hits[k]) mode_hits[k] = 0;
    gen_busy        = 1'b0;
    gen_ticks_left  = 0;
    gen_frames      = 0;
    send_idle_pct   = 13;
    recv_stall_pct  = 52;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle tick and unused mode from reset
    push_cmd(lgfs_pkg::MODE_TICK, 8'hFF, 6'd63);
    push_cmd(MODE_UNUSED, 8'hFF, 6'd63);
    // Byte extremes into channels 0..3
    push_cmd(lgfs_pkg::MODE_LOAD, 8'hFF, 6'd0);
    push_cmd(lgfs_pkg::MODE_LOAD, 8'h00, 6'd0);
    push_cmd(lgfs_pkg::MODE_LOAD, 8'h80, 6'd0);
    push_cmd(lgfs_pkg::MODE_LOAD, 8'h01, 6'd0);
    // Offset past the channel count wraps to 2, so the frame opens on 0x800
    push_cmd(lgfs_pkg::MODE_START, 8'h00, 6'd50);
    repeat (12) push_cmd(lgfs_pkg::MODE_TICK, 8'h00, 6'd0);
    // Restart, unused mode and a load, all mid-frame
    push_cmd(lgfs_pkg::MODE_START, 8'h00, 6'd0);
    push_cmd(MODE_UNUSED, 8'h00, 6'd0);
    push_cmd(lgfs_pkg::MODE_LOAD, 8'h5A, 6'd0);
    repeat (2) push_cmd(lgfs_pkg::MODE_TICK, 8'h00, 6'd0);

    queue_random(350);
    // Hold the sender until every outstanding result is back
    wait_idle();

    send_idle_pct  = 52;
    recv_stall_pct = 13;
    queue_random(350);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(350);
    while (gen_frames < 1) queue_random(1);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("beats: %0d loads, %0d starts, %0d ticks, %0d unused mode; %0d results checked",
             mode_hits[lgfs_pkg::MODE_LOAD], mode_hits[lgfs_pkg::MODE_START],
             mode_hits[lgfs_pkg::MODE_TICK], mode_hits[MODE_UNUSED], results_checked);
    $display("frames latched: %0d, write index wraps: %0d, mismatches: %0d",
             latches_seen, wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("led_grayscale_frame_serializer regression: pass");
    end else begin
      $display("led_grayscale_frame_serializer regression: fail");
    end
    $finish;
  end

endmodule
